### sv/grm_pkg.sv
// Package for the grid ray march column block: sizes, codes, shared types and
// the sine table builder.
// Depends on nothing; every other file imports it.
package grm_pkg;

  // Block sizes.
  localparam int GRID_SIZE   = 16;
  localparam int SCREEN_ROWS = 40;
  localparam int ANGLE_STEPS = 1024;

  localparam int GRID_W = $clog2(GRID_SIZE);
  localparam int ANG_W  = $clog2(ANGLE_STEPS);

  // Field widths.
  localparam int POS_W    = 12;
  localparam int HEAD_W   = 10;
  localparam int FOV_W    = 10;
  localparam int COLS_W   = 8;
  localparam int DIST_W   = 13;
  localparam int STEP_W   = 8;
  localparam int COL_W    = 8;
  localparam int ROWIDX_W = 4;
  localparam int WALLS_W  = 16;
  localparam int REASON_W = 2;
  localparam int CEIL_W   = 10;
  localparam int FLOOR_W  = 11;

  // Stream and configuration port widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 13;

  // Fixed point: position Q4.8, sine Q1.14, so position times direction is Q.22.
  localparam int SIN_W     = 16;
  localparam int SIN_FRAC  = 14;
  localparam int CELL_FRAC = 22;
  localparam int PROD_W    = SIN_W + DIST_W + 1;
  localparam int VW        = PROD_W + 1;

  // Divider widths, shared by the angle and the ceiling row divisions.
  localparam int WIDE_AF = (ANG_W > FOV_W) ? ANG_W : FOV_W;
  localparam int NUM_W   = WIDE_AF + 11;
  localparam int CNUM_W  = $clog2(SCREEN_ROWS * (1 << DIST_W));
  localparam int DIVD_W  = (NUM_W > CNUM_W) ? NUM_W : CNUM_W;
  localparam int DIVR_W  = DIST_W + 1;

  // Item kinds carried on in_tuser.
  localparam logic OP_CAST = 1'b0;
  localparam logic OP_MAP  = 1'b1;

  // Stop reasons.
  localparam logic [REASON_W-1:0] STOP_DEPTH = 2'd0;
  localparam logic [REASON_W-1:0] STOP_WALL  = 2'd1;
  localparam logic [REASON_W-1:0] STOP_EDGE  = 2'd2;

  // Configuration register indexes.
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_PLAYER_X,
    REG_PLAYER_Y,
    REG_HEADING,
    REG_FOV,
    REG_COLUMNS,
    REG_MAX_DIST,
    REG_STEP
  } cfg_idx_t;

  // Cast sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_ANUM,
    ST_ADIV,
    ST_MARCH,
    ST_CNUM,
    ST_CDIV,
    ST_POST
  } cast_state_t;

  // Command to the march unit.
  typedef struct packed {
    logic [ANG_W-1:0]  angle;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [DIST_W-1:0] max_dist;
    logic [STEP_W-1:0] step;
  } march_cmd_t;

  // Result of one march.
  typedef struct packed {
    logic [DIST_W-1:0]   travel;
    logic [REASON_W-1:0] reason;
  } march_res_t;

  typedef logic signed [SIN_W-1:0] sine_rom_t [ANGLE_STEPS];

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // Sine of 2*pi*i/ANGLE_STEPS in Q1.14 from a seven-term Taylor series on the
  // folded first quadrant, rounded to nearest.
  function automatic sine_rom_t build_sine();
    sine_rom_t       tab;
    longint unsigned p, quad, rem, t, x, x2, term, sum;
    longint          v;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      p    = 64'(i) * 64'd4;
      quad = p / ANGLE_STEPS;
      rem  = p % ANGLE_STEPS;
      if (quad[0]) begin
        rem = ANGLE_STEPS - rem;
      end
      t    = (rem << 30) / ANGLE_STEPS;
      x    = (t * HALF_PI_Q30) >> 30;
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      term = ((term * x2) >> 30) / 6;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 20;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 42;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 72;
      sum  = sum + term;
      term = ((term * x2) >> 30) / 110;
      sum  = sum - term;
      term = ((term * x2) >> 30) / 156;
      sum  = sum + term;
      v    = longint'((sum + 64'd32768) >> 16);
      if (v > 16384) begin
        v = 16384;
      end
      tab[i] = SIN_W'((quad >= 2) ? -v : v);
    end
    return tab;
  endfunction

endpackage

### sv/grm_divider.sv
// Restoring divider, one quotient bit per cycle, shared by the angle and the
// ceiling row calculations.
// Depends on grm_pkg for the operand widths.
module grm_divider import grm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DIVD_W-1:0] dividend,
  input  logic [DIVR_W-1:0] divisor,
  output logic              done,
  output logic [DIVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVD_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [DIVR_W-1:0] rem_r;
  logic [DIVR_W-1:0] dsr_r;
  logic [DIVD_W-1:0] quo_r;
  logic [DIVR_W:0]   trial;
  logic              fits;

  // Shift the next dividend bit into the partial remainder and try the divisor.
  assign trial = {rem_r, quo_r[DIVD_W-1]};
  assign fits  = (trial >= {1'b0, dsr_r});

  // Control: count the quotient bits and flag the last one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath: partial remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVD_W-2:0], fits};
      if (fits) begin
        rem_r <= DIVR_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_r <= trial[DIVR_W-1:0];
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

### sv/grm_wall_mem.sv
// Wall grid memory: one row of wall bits per entry, one write and one
// registered read per cycle. Rows never written read as the border layout.
// Depends on grm_pkg for the grid size.
module grm_wall_mem import grm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [GRID_W-1:0]    wr_row,
  input  logic [GRID_SIZE-1:0] wr_walls,
  input  logic [GRID_W-1:0]    rd_row,
  output logic [GRID_SIZE-1:0] rd_walls
);

  logic [GRID_SIZE-1:0] mem [GRID_SIZE];
  logic [GRID_SIZE-1:0] valid_r;
  logic [GRID_SIZE-1:0] rd_walls_r;

  // Layout after reset: the outer ring is wall, the interior is open.
  function automatic logic [GRID_SIZE-1:0] border_row(logic [GRID_W-1:0] row);
    logic [GRID_SIZE-1:0] edge_bits;
    edge_bits = GRID_SIZE'(1) | (GRID_SIZE'(1) << (GRID_SIZE - 1));
    if (row == '0 || row == GRID_W'(GRID_SIZE - 1)) begin
      return '1;
    end
    return edge_bits;
  endfunction

  // Row valid bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_row] <= 1'b1;
    end
  end

  // Storage write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_walls;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rd_walls_r <= valid_r[rd_row] ? mem[rd_row] : border_row(rd_row);
  end

  assign rd_walls = rd_walls_r;

endmodule

### sv/grm_march.sv
// March unit: sine and cosine lookup, then a step pipeline that
// issues one grid read per cycle and stops at the first wall, edge or limit.
// Depends on grm_pkg; reads the wall grid through grm_wall_mem in the top level.
module grm_march import grm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  march_cmd_t           cmd,
  output logic [GRID_W-1:0]    rd_row,
  input  logic [GRID_SIZE-1:0] rd_walls,
  output logic                 done,
  output march_res_t           res
);

  localparam sine_rom_t SINE_ROM = build_sine();
  localparam logic [ANG_W-1:0] QUARTER = ANG_W'(ANGLE_STEPS / 4);

  march_cmd_t              cmd_r;
  logic signed [SIN_W-1:0] sin_r;
  logic signed [SIN_W-1:0] cos_r;
  logic                    warm_r;
  logic                    gen_on_r;
  logic [DIST_W-1:0]       dist_gen_r;

  logic                    s1_valid_r;
  logic                    s1_last_r;
  logic [DIST_W-1:0]       s1_dist_r;

  logic                     s2_valid_r;
  logic                     s2_last_r;
  logic [DIST_W-1:0]        s2_dist_r;
  logic signed [PROD_W-1:0] s2_prod_x_r;
  logic signed [PROD_W-1:0] s2_prod_y_r;

  logic              s3_valid_r;
  logic              s3_last_r;
  logic              s3_oob_r;
  logic [GRID_W-1:0] s3_col_r;
  logic [DIST_W-1:0] s3_dist_r;

  logic              done_r;
  march_res_t        res_r;

  logic [DIST_W:0]       step_sum;
  logic [DIST_W-1:0]     dist_nxt;
  logic                  last_nxt;
  logic signed [VW-1:0]  vx;
  logic signed [VW-1:0]  vy;
  logic                  hit_wall;
  logic                  finish;

  // True when the Q.22 coordinate truncates to a cell inside the grid.
  function automatic logic axis_ok(logic signed [VW-1:0] v);
    logic neg_small;
    logic pos_in;
    neg_small = v[VW-1] && (&v[VW-1:CELL_FRAC]) && (|v[CELL_FRAC-1:0]);
    pos_in    = !v[VW-1] && (v[VW-2:CELL_FRAC] < (VW - 1 - CELL_FRAC)'(GRID_SIZE));
    return neg_small || pos_in;
  endfunction

  // Cell index; a small negative coordinate truncates to cell zero.
  function automatic logic [GRID_W-1:0] axis_cell(logic signed [VW-1:0] v);
    return v[VW-1] ? '0 : v[CELL_FRAC+GRID_W-1:CELL_FRAC];
  endfunction

  // Next march distance, clamped to the depth limit.
  assign step_sum = (DIST_W + 1)'(dist_gen_r) + (DIST_W + 1)'(cmd_r.step);
  assign dist_nxt = (step_sum >= (DIST_W + 1)'(cmd_r.max_dist)) ?
                    cmd_r.max_dist : step_sum[DIST_W-1:0];
  assign last_nxt = (dist_nxt == cmd_r.max_dist);

  // Ray point on each axis, position plus direction times distance.
  assign vx = $signed(VW'({cmd_r.pos_x, {SIN_FRAC{1'b0}}})) + VW'(s2_prod_x_r);
  assign vy = $signed(VW'({cmd_r.pos_y, {SIN_FRAC{1'b0}}})) + VW'(s2_prod_y_r);
  assign rd_row = axis_cell(vy);

  // The oldest step in flight decides; later steps are dropped.
  assign hit_wall = !s3_oob_r && rd_walls[s3_col_r];
  assign finish   = s3_valid_r && (s3_oob_r || hit_wall || s3_last_r);

  // Command latch and direction lookup.
  always_ff @(posedge clk) begin
    if (start) begin
      cmd_r <= cmd;
      sin_r <= SINE_ROM[cmd.angle];
      cos_r <= SINE_ROM[cmd.angle + QUARTER];
    end
  end

  // Step generator and pipeline control.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      warm_r     <= 1'b0;
      gen_on_r   <= 1'b0;
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      done_r <= 1'b0;
      warm_r <= start;
      if (start) begin
        dist_gen_r <= '0;
      end
      if (warm_r) begin
        if (cmd_r.max_dist == '0) begin
          done_r <= 1'b1;
        end else begin
          gen_on_r <= 1'b1;
        end
      end
      if (finish) begin
        gen_on_r   <= 1'b0;
        s1_valid_r <= 1'b0;
        s2_valid_r <= 1'b0;
        s3_valid_r <= 1'b0;
        done_r     <= 1'b1;
      end else begin
        s1_valid_r <= gen_on_r;
        s2_valid_r <= s1_valid_r;
        s3_valid_r <= s2_valid_r;
        if (gen_on_r) begin
          dist_gen_r <= dist_nxt;
          if (last_nxt) begin
            gen_on_r <= 1'b0;
          end
        end
      end
    end
  end

  // Pipeline payload: distance, products, cell and bounds.
  always_ff @(posedge clk) begin
    s1_dist_r   <= dist_nxt;
    s1_last_r   <= last_nxt;
    s2_dist_r   <= s1_dist_r;
    s2_last_r   <= s1_last_r;
    s2_prod_x_r <= sin_r * $signed({1'b0, s1_dist_r});
    s2_prod_y_r <= cos_r * $signed({1'b0, s1_dist_r});
    s3_dist_r   <= s2_dist_r;
    s3_last_r   <= s2_last_r;
    s3_col_r    <= axis_cell(vx);
    s3_oob_r    <= !(axis_ok(vx) && axis_ok(vy));
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (warm_r && cmd_r.max_dist == '0) begin
      res_r.travel <= '0;
      res_r.reason <= STOP_DEPTH;
    end else if (finish) begin
      if (s3_oob_r) begin
        res_r.travel <= cmd_r.max_dist;
        res_r.reason <= STOP_EDGE;
      end else if (hit_wall) begin
        res_r.travel <= s3_dist_r;
        res_r.reason <= STOP_WALL;
      end else begin
        res_r.travel <= s3_dist_r;
        res_r.reason <= STOP_DEPTH;
      end
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

### sv/grid_ray_march_column.sv
// Column ray caster over a 16 by 16 wall-bit grid. A cast beat (in_tuser low)
// names a screen column; the block forms the ray angle, marches the ray one
// step per cycle through a pipelined grid lookup and returns one beat with the
// distance, stop reason, ceiling row and floor row. A map beat (in_tuser high)
// replaces one grid row and returns nothing. A ray stops after at most
// ceil(max_distance / step_length) march steps, 158 at the reset values;
// the grid memory serves one read per step, and the angle and (for a nonzero
// distance) the ceiling row each pass through a shared divider that yields
// one quotient bit per cycle.
// Input is accepted only between casts; a finished result waits in the output
// register while the next beat is taken. There is no clearing pass after reset.
// Depends on grm_pkg, grm_divider, grm_wall_mem and grm_march.
module grid_ray_march_column import grm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // column[7:0], row_index[11:8], row_walls[27:12]
  input  logic                  in_tuser,   // op
  // Result stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // distance[12:0], stop_reason[14:13],
                                            // ceiling_row[24:15], floor_row[35:25]
  // Configuration write port.
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int ROW_EXT_W  = (GRID_W + 1 > ROWIDX_W + 1) ? GRID_W + 1 : ROWIDX_W + 1;
  localparam int WALL_EXT_W = (GRID_SIZE > WALLS_W) ? GRID_SIZE : WALLS_W;
  localparam logic [CEIL_W-1:0] CEIL_MIN = {1'b1, {(CEIL_W - 1){1'b0}}};
  localparam logic [CEIL_W-1:0] CEIL_MAX = {1'b0, {(CEIL_W - 1){1'b1}}};
  localparam int OUT_PAD_W = OUT_DATA_W - DIST_W - REASON_W - CEIL_W - FLOOR_W;

  // Configuration registers.
  logic [POS_W-1:0]  player_x_r;
  logic [POS_W-1:0]  player_y_r;
  logic [HEAD_W-1:0] heading_r;
  logic [FOV_W-1:0]  fov_r;
  logic [COLS_W-1:0] columns_r;
  logic [DIST_W-1:0] max_dist_r;
  logic [STEP_W-1:0] step_r;

  cast_state_t state_r, state_nxt;

  logic [COL_W-1:0]          col_r;
  logic [ANG_W+COLS_W-1:0]   p_head_r;
  logic [COL_W+FOV_W-1:0]    p_col_r;
  logic [FOV_W+COLS_W-1:0]   p_fov_r;
  logic [DIST_W-1:0]         dist_r;
  logic [REASON_W-1:0]       reason_r;
  logic [CEIL_W-1:0]         ceil_r;
  logic                      neg_r;
  logic                      out_tvalid_r;
  logic [OUT_DATA_W-1:0]     out_tdata_r;

  logic                      in_fire;
  logic [COLS_W-1:0]         cc_eff;
  logic [STEP_W-1:0]         step_eff;
  logic [NUM_W-1:0]          ang_num;
  logic [CNUM_W:0]           cnum;
  logic [CNUM_W-1:0]         cnum_mag;
  logic [CEIL_W-1:0]         ceil_div;
  logic [FLOOR_W-1:0]        floor_val;
  logic                      out_free;

  logic                      div_start;
  logic [DIVD_W-1:0]         div_dividend;
  logic [DIVR_W-1:0]         div_divisor;
  logic                      div_done;
  logic [DIVD_W-1:0]         div_quo;

  logic                      march_start;
  march_cmd_t                march_cmd;
  logic                      march_done;
  march_res_t                march_res;
  logic [GRID_W-1:0]         grid_rd_row;
  logic [GRID_SIZE-1:0]      grid_rd_walls;

  logic [ROW_EXT_W-1:0]      row_ext;
  logic [WALL_EXT_W-1:0]     walls_ext;
  logic                      map_wr;

  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid_r || out_tready;

  // Zero column count and zero step length act as one.
  assign cc_eff   = (columns_r == '0) ? COLS_W'(1) : columns_r;
  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;

  // Map beats write the grid straight away; rows beyond the grid are dropped.
  assign row_ext   = ROW_EXT_W'(in_tdata[COL_W +: ROWIDX_W]);
  assign walls_ext = WALL_EXT_W'(in_tdata[COL_W + ROWIDX_W +: WALLS_W]);
  assign map_wr    = in_fire && (in_tuser == OP_MAP) &&
                     (row_ext < ROW_EXT_W'(GRID_SIZE));

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      player_x_r <= '0;
      player_y_r <= '0;
      heading_r  <= '0;
      fov_r      <= FOV_W'(128);
      columns_r  <= COLS_W'(120);
      max_dist_r <= DIST_W'(4096);
      step_r     <= STEP_W'(26);
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_addr))
        REG_PLAYER_X: player_x_r <= cfg_wdata[POS_W-1:0];
        REG_PLAYER_Y: player_y_r <= cfg_wdata[POS_W-1:0];
        REG_HEADING:  heading_r  <= cfg_wdata[HEAD_W-1:0];
        REG_FOV:      fov_r      <= cfg_wdata[FOV_W-1:0];
        REG_COLUMNS:  columns_r  <= cfg_wdata[COLS_W-1:0];
        REG_MAX_DIST: max_dist_r <= cfg_wdata[DIST_W-1:0];
        REG_STEP:     step_r     <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Angle numerator: 2*cc*heading + 2*col*fov + 4*cc*ANGLE_STEPS - cc*fov.
  assign ang_num = NUM_W'({p_head_r, 1'b0}) + NUM_W'({p_col_r, 1'b0}) +
                   (NUM_W'(cc_eff) << (ANG_W + 2)) - NUM_W'(p_fov_r);

  // Ceiling numerator: rows*d - 512*rows, divided later by 2*d.
  assign cnum     = (CNUM_W + 1)'(dist_r) * (CNUM_W + 1)'(SCREEN_ROWS) -
                    (CNUM_W + 1)'(512 * SCREEN_ROWS);
  assign cnum_mag = cnum[CNUM_W] ? CNUM_W'(-cnum) : cnum[CNUM_W-1:0];

  // Quotient to ceiling row, truncated toward zero and saturated.
  always_comb begin
    if (neg_r) begin
      ceil_div = (div_quo > DIVD_W'(1 << (CEIL_W - 1))) ?
                 CEIL_MIN : CEIL_W'(DIVD_W'(0) - div_quo);
    end else begin
      ceil_div = (div_quo > DIVD_W'((1 << (CEIL_W - 1)) - 1)) ?
                 CEIL_MAX : div_quo[CEIL_W-1:0];
    end
  end

  assign floor_val = FLOOR_W'(SCREEN_ROWS) -
                     {{(FLOOR_W - CEIL_W){ceil_r[CEIL_W-1]}}, ceil_r};

  // March command from the configuration and the angle quotient.
  assign march_cmd.angle    = div_quo[ANG_W-1:0];
  assign march_cmd.pos_x    = player_x_r;
  assign march_cmd.pos_y    = player_y_r;
  assign march_cmd.max_dist = max_dist_r;
  assign march_cmd.step     = step_eff;

  // Sequencer: next state and unit controls.
  always_comb begin
    state_nxt    = state_r;
    div_start    = 1'b0;
    div_dividend = DIVD_W'(ang_num);
    div_divisor  = DIVR_W'({cc_eff, 1'b0});
    march_start  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && in_tuser == OP_CAST) begin
          state_nxt = ST_PROD;
        end
      end
      ST_PROD: begin
        state_nxt = ST_ANUM;
      end
      ST_ANUM: begin
        div_start = 1'b1;
        state_nxt = ST_ADIV;
      end
      ST_ADIV: begin
        if (div_done) begin
          march_start = 1'b1;
          state_nxt   = ST_MARCH;
        end
      end
      ST_MARCH: begin
        if (march_done) begin
          state_nxt = (march_res.travel == '0) ? ST_POST : ST_CNUM;
        end
      end
      ST_CNUM: begin
        div_start    = 1'b1;
        div_dividend = DIVD_W'(cnum_mag);
        div_divisor  = DIVR_W'({dist_r, 1'b0});
        state_nxt    = ST_CDIV;
      end
      ST_CDIV: begin
        if (div_done) begin
          state_nxt = ST_POST;
        end
      end
      ST_POST: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Cast working registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      col_r <= in_tdata[COL_W-1:0];
    end
    if (state_r == ST_PROD) begin
      p_head_r <= ANG_W'(heading_r) * cc_eff;
      p_col_r  <= col_r * fov_r;
      p_fov_r  <= fov_r * cc_eff;
    end
    if (state_r == ST_MARCH && march_done) begin
      dist_r   <= march_res.travel;
      reason_r <= march_res.reason;
      ceil_r   <= CEIL_MIN;
    end
    if (state_r == ST_CNUM) begin
      neg_r <= cnum[CNUM_W];
    end
    if (state_r == ST_CDIV && div_done) begin
      ceil_r <= ceil_div;
    end
  end

  // Output register: one beat per cast.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (state_r == ST_POST && out_free) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_POST && out_free) begin
      out_tdata_r <= {{OUT_PAD_W{1'b0}}, floor_val, ceil_r, reason_r, dist_r};
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  grm_divider u_divider (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quo)
  );

  grm_wall_mem u_wall_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (map_wr),
    .wr_row   (row_ext[GRID_W-1:0]),
    .wr_walls (walls_ext[GRID_SIZE-1:0]),
    .rd_row   (grid_rd_row),
    .rd_walls (grid_rd_walls)
  );

  grm_march u_march (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (march_start),
    .cmd      (march_cmd),
    .rd_row   (grid_rd_row),
    .rd_walls (grid_rd_walls),
    .done     (march_done),
    .res      (march_res)
  );

endmodule

### tb/grid_ray_march_column_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for grid_ray_march_column: a queue-fed stream driver,
// a result monitor and a predictor of each column ray march result.
// Depends on grm_pkg and the grid_ray_march_column RTL.
module grid_ray_march_column_tb;
  import grm_pkg::*;

  localparam int STALL_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 80;
  localparam int END_CYCLES    = 200;
  localparam int LONG_HOLD     = 600;
  localparam int HOLD_AFTER    = 150;
  localparam longint CELL_DIV  = 64'sd1 << CELL_FRAC;
  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;
  localparam logic [WALLS_W-1:0] EDGE_ROW = WALLS_W'(1) | (WALLS_W'(1) << (GRID_SIZE - 1));
  localparam logic [WALLS_W-1:0] FULL_ROW = '1;

  // One input command.
  typedef struct packed {
    logic                op;
    logic [COL_W-1:0]    column;
    logic [ROWIDX_W-1:0] row;
    logic [WALLS_W-1:0]  walls;
  } march_cmd_item_t;

  // Viewer and march settings as held in the block's registers.
  typedef struct packed {
    logic [POS_W-1:0]  px;
    logic [POS_W-1:0]  py;
    logic [HEAD_W-1:0] head;
    logic [FOV_W-1:0]  fov;
    logic [COLS_W-1:0] cols;
    logic [DIST_W-1:0] maxd;
    logic [STEP_W-1:0] step;
  } view_cfg_t;

  // One wall slice as returned on the result stream.
  typedef struct packed {
    logic [DIST_W-1:0]          travel;
    logic [REASON_W-1:0]        reason;
    logic signed [CEIL_W-1:0]   ceil_row;
    logic signed [FLOOR_W-1:0]  floor_row;
  } column_slice_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor state and the queues between the processes.
  int               sine_lut [ANGLE_STEPS];
  logic [GRID_SIZE-1:0] wall_map [GRID_SIZE];
  view_cfg_t        view;
  march_cmd_item_t  cmd_q [$];
  column_slice_t    slice_q [$];
  march_cmd_item_t  cur_cmd;
  int               gap_left = 0;
  int               hold_left = 0;
  bit               long_hold_done = 1'b0;
  bit               calm = 1'b0;
  int               results_seen = 0;
  int               mismatches = 0;
  int               idle_cycles = 0;

  grid_ray_march_column dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Sine in Q1.14 from a seven-term series on the folded first quadrant.
  function automatic int sine_q14(input int idx);
    longint unsigned p, quad, rem, t, x, x2, term, sum;
    longint v;
    p    = 64'(idx) * 64'd4;
    quad = p / ANGLE_STEPS;
    rem  = p % ANGLE_STEPS;
    if (quad[0]) begin
      rem = ANGLE_STEPS - rem;
    end
    t    = (rem << 30) / ANGLE_STEPS;
    x    = (t * HALF_PI_Q30) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    for (int k = 1; k <= 6; k++) begin
      term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
      if (k % 2 == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    v = longint'((sum + 64'd32768) >> 16);
    if (v > 16384) begin
      v = 16384;
    end
    return (quad >= 2) ? -int'(v) : int'(v);
  endfunction

  // Marches one column's ray over the predicted wall map.
  function automatic column_slice_t cast_column(input view_cfg_t v, input logic [COL_W-1:0] col);
    longint unsigned cc, stp, num, ang, d, lim;
    longint sx, cy, px, py, tx, ty, ceil_v;
    logic [REASON_W-1:0] why;
    column_slice_t r;
    cc  = (v.cols == 0) ? 64'd1 : 64'(v.cols);
    stp = (v.step == 0) ? 64'd1 : 64'(v.step);
    num = 64'(v.head) * 2 * cc + 2 * 64'(col) * 64'(v.fov)
        + 4 * cc * ANGLE_STEPS - 64'(v.fov) * cc;
    ang = (num / (2 * cc)) % ANGLE_STEPS;
    sx  = sine_lut[ang];
    cy  = sine_lut[(ang + ANGLE_STEPS / 4) % ANGLE_STEPS];
    px  = longint'(64'(v.px)) << SIN_FRAC;
    py  = longint'(64'(v.py)) << SIN_FRAC;
    lim = 64'(v.maxd);
    d   = 0;
    why = STOP_DEPTH;
    while (d < lim) begin
      d = d + stp;
      if (d > lim) begin
        d = lim;
      end
      // Signed division truncates toward zero, as the cell lookup does.
      tx = (px + sx * longint'(d)) / CELL_DIV;
      ty = (py + cy * longint'(d)) / CELL_DIV;
      if (tx < 0 || tx >= GRID_SIZE || ty < 0 || ty >= GRID_SIZE) begin
        d   = lim;
        why = STOP_EDGE;
        break;
      end
      if (wall_map[ty][tx]) begin
        why = STOP_WALL;
        break;
      end
    end
    if (d == 0) begin
      ceil_v = -512;
    end else begin
      ceil_v = (SCREEN_ROWS * longint'(d) - 512 * SCREEN_ROWS) / (2 * longint'(d));
      if (ceil_v < -512) ceil_v = -512;
      if (ceil_v > 511) ceil_v = 511;
    end
    r.travel    = DIST_W'(d);
    r.reason    = why;
    r.ceil_row  = CEIL_W'(ceil_v);
    r.floor_row = FLOOR_W'(SCREEN_ROWS - ceil_v);
    return r;
  endfunction

  // Input driver: presents queued commands and predicts each accepted beat.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        if (cur_cmd.op == OP_MAP) begin
          wall_map[cur_cmd.row] = cur_cmd.walls;
        end else begin
          slice_q.push_back(cast_column(view, cur_cmd.column));
        end
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (cmd_q.size() > 0) begin
          cur_cmd = cmd_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= IN_DATA_W'({cur_cmd.walls, cur_cmd.row, cur_cmd.column});
          in_tuser  <= cur_cmd.op;
          if (!calm && $urandom_range(0, 99) < 12) begin
            gap_left = $urandom_range(1, 10);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each beat against the oldest predicted slice and
  // paces out_tready, with one long hold-off so the block backs up.
  always @(posedge clk) begin
    column_slice_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        results_seen++;
        got.travel    = out_tdata[DIST_W-1:0];
        got.reason    = out_tdata[DIST_W +: REASON_W];
        got.ceil_row  = out_tdata[DIST_W + REASON_W +: CEIL_W];
        got.floor_row = out_tdata[DIST_W + REASON_W + CEIL_W +: FLOOR_W];
        if (slice_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: result beat with no slice expected: %h", $realtime, out_tdata);
          end
        end else begin
          want = slice_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: slice mismatch: dist %0d/%0d reason %0d/%0d ceil %0d/%0d floor %0d/%0d (expected/actual)",
                       $realtime, want.travel, got.travel, want.reason, got.reason,
                       want.ceil_row, got.ceil_row, want.floor_row, got.floor_row);
            end
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 99) < 12) begin
        hold_left = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run if no beat or register write happens for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic add_cast(input int col);
    march_cmd_item_t c;
    c.op     = OP_CAST;
    c.column = COL_W'(col);
    c.row    = ROWIDX_W'($urandom);
    c.walls  = WALLS_W'($urandom);
    cmd_q.push_back(c);
  endtask

  task automatic add_map(input int row, input logic [WALLS_W-1:0] walls);
    march_cmd_item_t c;
    c.op     = OP_MAP;
    c.column = COL_W'($urandom);
    c.row    = ROWIDX_W'(row);
    c.walls  = walls;
    cmd_q.push_back(c);
  endtask

  // Waits until every command has gone in and every slice has come out; the
  // check runs at the falling edge, once the driver's updates have settled.
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_q.size() != 0 || in_tvalid || slice_q.size() != 0) begin
      @(negedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write, mirrored into the predictor's copy.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= CFG_DATA_W'(val);
    case (idx)
      REG_PLAYER_X: view.px   = POS_W'(val);
      REG_PLAYER_Y: view.py   = POS_W'(val);
      REG_HEADING:  view.head = HEAD_W'(val);
      REG_FOV:      view.fov  = FOV_W'(val);
      REG_COLUMNS:  view.cols = COLS_W'(val);
      REG_MAX_DIST: view.maxd = DIST_W'(val);
      REG_STEP:     view.step = STEP_W'(val);
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_view(input int px, input int py, input int head, input int fov,
                            input int cols, input int maxd, input int step);
    write_reg(REG_PLAYER_X, px);
    write_reg(REG_PLAYER_Y, py);
    write_reg(REG_HEADING, head);
    write_reg(REG_FOV, fov);
    write_reg(REG_COLUMNS, cols);
    write_reg(REG_MAX_DIST, maxd);
    write_reg(REG_STEP, step);
  endtask

  initial begin : stimulus
    int px, py, cols, step, maxd, col, row, pick;
    logic [WALLS_W-1:0] walls;
    for (int i = 0; i < ANGLE_STEPS; i++) begin
      sine_lut[i] = sine_q14(i);
    end
    for (int r = 0; r < GRID_SIZE; r++) begin
      wall_map[r] = (r == 0 || r == GRID_SIZE - 1) ? FULL_ROW : EDGE_ROW;
    end
    view = '{px: '0, py: '0, head: '0, fov: FOV_W'(128), cols: COLS_W'(120),
             maxd: DIST_W'(4096), step: STEP_W'(26)};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: the viewer sits in the corner wall cell.
    add_cast(0);
    add_cast(255);
    wait_idle();

    // Centre of the map, default view, with a wall row added and removed.
    write_view(2048, 2048, 0, 128, 120, 4096, 26);
    add_cast(0);
    add_cast(60);
    add_cast(119);
    add_cast(200);
    add_map(12, FULL_ROW);
    add_cast(60);
    add_map(12, EDGE_ROW);
    wait_idle();

    // Every register at its top value.
    write_view(4095, 4095, 1023, 1023, 255, 8191, 255);
    add_cast(0);
    add_cast(128);
    add_cast(255);
    wait_idle();

    // Zero column count, zero step length and zero field of view.
    write_view(1000, 1500, 512, 0, 0, 300, 0);
    add_cast(0);
    add_cast(255);
    wait_idle();

    // Zero depth limit: no step is taken.
    write_view(2048, 2048, 100, 1023, 1, 0, 26);
    add_cast(7);
    wait_idle();

    // A ray heading towards negative x from just inside cell 0 of an open row;
    // the write to the spare index must change nothing.
    write_view(10, 2176, 768, 0, 1, 4096, 26);
    write_reg(REG_UNUSED, 8191);
    add_map(8, '0);
    add_cast(0);
    add_map(8, EDGE_ROW);
    wait_idle();

    // Random phases, each with its own view; the last runs without random gaps or hold-offs.
    for (int ph = 0; ph < 8; ph++) begin
      px   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(256, 3839);
      py   = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095) : $urandom_range(256, 3839);
      cols = ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 255);
      step = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 7) : $urandom_range(8, 255);
      // Short steps get a short depth so that one cast stays bounded.
      if (step < 8) begin
        maxd = $urandom_range(0, 1024);
      end else begin
        pick = $urandom_range(0, 9);
        maxd = (pick == 0) ? 8191 : (pick == 1) ? $urandom_range(0, 64) : $urandom_range(1, 4096);
      end
      write_view(px, py, $urandom_range(0, 1023), $urandom_range(0, 1023), cols, maxd, step);
      if (ph == 7) begin
        calm = 1'b1;
      end
      for (int n = 0; n < 98; n++) begin
        if ($urandom_range(0, 99) < 20) begin
          row  = $urandom_range(0, GRID_SIZE - 1);
          pick = $urandom_range(0, 99);
          if (pick < 60) begin
            // Sparse interior walls inside an intact border.
            walls = WALLS_W'($urandom & $urandom & $urandom);
            walls = (row == 0 || row == GRID_SIZE - 1) ? FULL_ROW : (walls | EDGE_ROW);
          end else if (pick < 85) begin
            walls = WALLS_W'($urandom);
          end else begin
            // Open row ends so that rays can leave the grid.
            walls = WALLS_W'($urandom & $urandom & $urandom) & ~EDGE_ROW;
          end
          add_map(row, walls);
        end else begin
          if ($urandom_range(0, 1) == 0 && view.cols != 0) begin
            col = $urandom_range(0, int'(view.cols) - 1);
          end else begin
            col = $urandom_range(0, 255);
          end
          add_cast(col);
        end
      end
      wait_idle();
    end

    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0 && slice_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### sim.f
sv/grm_pkg.sv
sv/grm_divider.sv
sv/grm_wall_mem.sv
sv/grm_march.sv
sv/grid_ray_march_column.sv
tb/grid_ray_march_column_tb.sv
